// ===== design/scba_pkg.sv =====
package scba_pkg;

  localparam int NUM_CLASSES      = 6;
  localparam int MIN_BLOCK_BYTES  = 64;
  localparam int BLOCKS_PER_CLASS = 64;

  localparam int MIN_SHIFT = $clog2(MIN_BLOCK_BYTES);

  // Fixed field widths
  localparam int CLS_W    = 3;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;

  localparam int CIDX_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W     = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
  localparam int CNT_W      = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int RING_DEPTH = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int RADDR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Region offsets are carried one bit above the address width
  localparam int START_W = ADDR_W + 1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_OUTSIDE  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ACCESS,
    S_READ
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic decode;
    logic access;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic alloc_go;
  } sts_t;

  function automatic logic [START_W-1:0] class_bytes(input int unsigned c);
    logic [63:0] v;
    v = 64'(MIN_BLOCK_BYTES) << c;
    return v[START_W-1:0];
  endfunction

  function automatic logic [START_W-1:0] class_start(input int unsigned c);
    logic [63:0] v;
    v = 64'(MIN_BLOCK_BYTES) * 64'(BLOCKS_PER_CLASS) * ((64'd1 << c) - 64'd1);
    return v[START_W-1:0];
  endfunction

  localparam logic [START_W-1:0] MAX_BYTES = class_bytes(NUM_CLASSES - 1);

endpackage

// ===== design/size_class_block_allocator_core.sv =====
// Fixed-block allocator with six size classes (64 to 2048 bytes, 64 blocks each),
// regions packed upward from region_base. Pulse start while busy is low; a free
// or any error answers with done once its request is decoded and checked against
// its class; a good allocate also reads the class ring (a synchronous RAM) and
// forms the address. busy stays high until the answer is registered, so one
// request is in flight at a time. The done beat lasts one cycle and cannot be
// held off. After reset the block stays busy while it loads the free rings;
// region_base may be written at any time (cfg_ready is always high) but must
// only change while no request is in flight.
module size_class_block_allocator_core import scba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cmd,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [ADDR_W-1:0]   free_addr,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ADDR_W-1:0]   cfg_data,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [ADDR_W-1:0]   block_addr,
  output logic [CLS_W-1:0]    size_class
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  scba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  scba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .req_size   (req_size),
    .free_addr  (free_addr),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .block_addr (block_addr),
    .size_class (size_class)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while a request is still in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (size_class < CLS_W'(NUM_CLASSES)))
    else $error("reported class out of range");

  a_err_addr: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (block_addr == '0))
    else $error("nonzero address on an error result");

  a_err_cls: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == ST_BAD_SIZE) || (status == ST_OUTSIDE))) |-> (size_class == '0))
    else $error("class reported on a size or range error");

endmodule

// ===== design/scba_ram.sv =====
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/scba_ctrl.sv =====
module scba_ctrl import scba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.decode = 1'b1;
        state_next = S_ACCESS;
      end
      S_ACCESS: begin
        ctl.access = 1'b1;
        state_next = sts.alloc_go ? S_READ : S_IDLE;
      end
      S_READ: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== design/scba_dp.sv =====
module scba_dp import scba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic              cmd,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [ADDR_W-1:0] free_addr,
  input  logic              cfg_valid,
  input  logic [ADDR_W-1:0] cfg_data,
  output logic              done,
  output logic [STATUS_W-1:0] status,
  output logic [ADDR_W-1:0] block_addr,
  output logic [CLS_W-1:0]  size_class
);

  logic [ADDR_W-1:0]  region_base;

  logic               cmd_q;
  logic [SIZE_W-1:0]  size_q;
  logic [ADDR_W-1:0]  faddr_q;

  logic [CLS_W-1:0]   cls_q;
  status_t            st_q;
  logic [START_W-1:0] off_q;
  logic [START_W-1:0] sel_start;
  logic [ADDR_W-1:0]  base_start;

  logic [SLOT_W-1:0]  head  [NUM_CLASSES];
  logic [SLOT_W-1:0]  tail  [NUM_CLASSES];
  logic [CNT_W-1:0]   count [NUM_CLASSES];

  logic [RADDR_W-1:0] clr_addr;
  logic [SLOT_W-1:0]  clr_slot;

  // decode stage
  logic [CLS_W-1:0]   acls;
  logic [CLS_W-1:0]   fcls;
  logic [CLS_W-1:0]   cls_d;
  status_t            st_d;
  logic [START_W-1:0] off_d;
  logic [START_W-1:0] start_d;
  logic               in_range;
  logic               bad_size;

  always_comb begin
    acls     = '0;
    fcls     = '0;
    off_d    = {1'b0, faddr_q - region_base};
    in_range = (off_d < class_start(NUM_CLASSES));
    bad_size = (size_q == '0) || (START_W'(size_q) > MAX_BYTES);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (START_W'(size_q) > class_bytes(c)) begin
        acls = CLS_W'(c + 1);
      end
      if (off_d >= class_start(c)) begin
        fcls = CLS_W'(c);
      end
    end
    if (cmd_q == CMD_ALLOC) begin
      st_d  = bad_size ? ST_BAD_SIZE : ST_OK;
      cls_d = bad_size ? '0 : acls;
    end else begin
      st_d  = in_range ? ST_OK : ST_OUTSIDE;
      cls_d = in_range ? fcls : '0;
    end
    start_d = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls_d == CLS_W'(c)) begin
        start_d = class_start(c);
      end
    end
  end

  // access stage
  logic [CIDX_W-1:0]  ci;
  logic [CNT_W-1:0]   cnt;
  logic [SLOT_W-1:0]  hd;
  logic [SLOT_W-1:0]  tl;
  status_t            acc_st;
  logic               alloc_go;
  logic               free_go;
  logic [START_W-1:0] rel;
  logic [SLOT_W-1:0]  blk;
  logic [RADDR_W-1:0] ring_base;
  logic               ram_we;
  logic [RADDR_W-1:0] ram_waddr;
  logic [SLOT_W-1:0]  ram_wdata;
  logic [RADDR_W-1:0] ram_raddr;
  logic [SLOT_W-1:0]  ram_rdata;

  always_comb begin
    ci  = cls_q[CIDX_W-1:0];
    cnt = count[ci];
    hd  = head[ci];
    tl  = tail[ci];
    if (st_q != ST_OK) begin
      acc_st = st_q;
    end else if (cmd_q == CMD_ALLOC) begin
      acc_st = (cnt == '0) ? ST_EMPTY : ST_OK;
    end else begin
      acc_st = (cnt >= CNT_W'(BLOCKS_PER_CLASS)) ? ST_FULL : ST_OK;
    end
    alloc_go  = (acc_st == ST_OK) && (cmd_q == CMD_ALLOC);
    free_go   = (acc_st == ST_OK) && (cmd_q == CMD_FREE);
    rel       = off_q - sel_start;
    blk       = SLOT_W'(rel >> (MIN_SHIFT + cls_q));
    ring_base = RADDR_W'(ci) * RADDR_W'(BLOCKS_PER_CLASS);
    ram_raddr = ring_base + RADDR_W'(hd);
    ram_we    = ctl.clr_wr || (ctl.access && free_go);
    ram_waddr = ctl.clr_wr ? clr_addr : (ring_base + RADDR_W'(tl));
    ram_wdata = ctl.clr_wr ? clr_slot : blk;
  end

  assign sts.alloc_go = alloc_go;
  assign sts.clr_last = (clr_addr == RADDR_W'(RING_DEPTH - 1));

  scba_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.access && alloc_go),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
    end else if (cfg_valid) begin
      region_base <= cfg_data;
    end
  end

  // sweep the ring once after reset: slot i of each class holds block i
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_slot <= '0;
    end else if (ctl.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
      clr_slot <= (clr_slot == SLOT_W'(BLOCKS_PER_CLASS - 1)) ? '0 : clr_slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= cmd;
      size_q  <= req_size;
      faddr_q <= free_addr;
    end
    if (ctl.decode) begin
      cls_q     <= cls_d;
      st_q      <= st_d;
      off_q     <= off_d;
      sel_start <= start_d;
    end
    if (ctl.access) begin
      base_start <= region_base + sel_start[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= CNT_W'(BLOCKS_PER_CLASS);
      end
    end else if (ctl.access) begin
      if (alloc_go) begin
        head[ci]  <= (hd == SLOT_W'(BLOCKS_PER_CLASS - 1)) ? '0 : hd + 1'b1;
        count[ci] <= cnt - 1'b1;
      end else if (free_go) begin
        tail[ci]  <= (tl == SLOT_W'(BLOCKS_PER_CLASS - 1)) ? '0 : tl + 1'b1;
        count[ci] <= cnt + 1'b1;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctl.access && !alloc_go) || ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.access && !alloc_go) begin
      status     <= acc_st;
      block_addr <= '0;
      size_class <= cls_q;
    end else if (ctl.finish) begin
      status     <= ST_OK;
      block_addr <= base_start + (ADDR_W'(ram_rdata) << (MIN_SHIFT + cls_q));
      size_class <= cls_q;
    end
  end

endmodule

// ===== dv/tb_size_class_block_allocator_core.sv =====
module tb_size_class_block_allocator_core;
  import scba_pkg::*;

  localparam int TOP_BYTES   = MIN_BLOCK_BYTES << (NUM_CLASSES - 1);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t            st;
    logic [ADDR_W-1:0]  addr;
    logic [CLS_W-1:0]   cls;
  } answer_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                cmd;
  logic [SIZE_W-1:0]   req_size;
  logic [ADDR_W-1:0]   free_addr;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ADDR_W-1:0]   cfg_data;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   block_addr;
  logic [CLS_W-1:0]    size_class;

  // Allocator image: per-class rings of free block indexes
  logic [SLOT_W-1:0] ring_slot [NUM_CLASSES][BLOCKS_PER_CLASS];
  logic [SLOT_W-1:0] ring_rd [NUM_CLASSES];
  logic [SLOT_W-1:0] ring_wr [NUM_CLASSES];
  logic [CNT_W-1:0]  blocks_free [NUM_CLASSES];
  logic [ADDR_W-1:0] base_addr;

  answer_t     answers_due [$];
  int unsigned held_blocks [$];
  int unsigned errors;
  int unsigned cycle_count;
  bit          no_idle;

  size_class_block_allocator_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .req_size   (req_size),
    .free_addr  (free_addr),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .block_addr (block_addr),
    .size_class (size_class)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] region_offset(input int unsigned k);
    return ADDR_W'(MIN_BLOCK_BYTES * BLOCKS_PER_CLASS * ((1 << k) - 1));
  endfunction

  function automatic logic [SIZE_W-1:0] size_for_class(input int unsigned k);
    int unsigned lo;
    lo = (k == 0) ? 1 : (MIN_BLOCK_BYTES << (k - 1)) + 1;
    return SIZE_W'($urandom_range(MIN_BLOCK_BYTES << k, lo));
  endfunction

  function automatic answer_t allocator_answer(input logic op, input logic [SIZE_W-1:0] bytes,
                                               input logic [ADDR_W-1:0] addr);
    answer_t           a;
    int unsigned       c;
    logic [ADDR_W-1:0] off;
    logic [SLOT_W-1:0] blk;
    a.st = ST_OK;
    a.addr = '0;
    a.cls = '0;
    if (op == CMD_ALLOC) begin
      if (bytes == 0 || bytes > TOP_BYTES) begin
        a.st = ST_BAD_SIZE;
        return a;
      end
      c = 0;
      while ((MIN_BLOCK_BYTES << c) < bytes) c++;
      a.cls = CLS_W'(c);
      if (blocks_free[c] == 0) begin
        a.st = ST_EMPTY;
        return a;
      end
      blk = ring_slot[c][ring_rd[c]];
      ring_rd[c] = ring_rd[c] + 1'b1;
      blocks_free[c] = blocks_free[c] - 1'b1;
      a.addr = base_addr + region_offset(c) + (ADDR_W'(blk) << (MIN_SHIFT + c));
    end else begin
      off = addr - base_addr;
      c = 0;
      while (c < NUM_CLASSES && off >= region_offset(c + 1)) c++;
      if (c == NUM_CLASSES) begin
        a.st = ST_OUTSIDE;
        return a;
      end
      a.cls = CLS_W'(c);
      if (blocks_free[c] >= BLOCKS_PER_CLASS) begin
        a.st = ST_FULL;
        return a;
      end
      // align down to the block start
      blk = SLOT_W'((off - region_offset(c)) >> (MIN_SHIFT + c));
      ring_slot[c][ring_wr[c]] = blk;
      ring_wr[c] = ring_wr[c] + 1'b1;
      blocks_free[c] = blocks_free[c] + 1'b1;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done === 1'b1) begin
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d addr %h class %0d",
                 $time, status, block_addr, size_class);
      end else begin
        want = answers_due.pop_front();
        if (status !== want.st) begin
          errors++;
          $display("%0t: status expected %0d, got %0d", $time, want.st, status);
        end
        if (block_addr !== want.addr) begin
          errors++;
          $display("%0t: block_addr expected %h, got %h", $time, want.addr, block_addr);
        end
        if (size_class !== want.cls) begin
          errors++;
          $display("%0t: size_class expected %0d, got %0d", $time, want.cls, size_class);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the accepting beat
  // with start still high, so back-to-back requests keep it asserted.
  task automatic send_request(input logic op, input logic [SIZE_W-1:0] bytes,
                              input logic [ADDR_W-1:0] addr, output answer_t ans);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(19, 0);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = op;
    req_size = bytes;
    free_addr = addr;
    start = 1'b1;
    do @(posedge clk); while (busy);
    ans = allocator_answer(op, bytes, addr);
    answers_due.push_back(ans);
    @(negedge clk);
  endtask

  task automatic set_region_base(input logic [ADDR_W-1:0] value);
    start = 1'b0;
    wait (answers_due.size() == 0);
    // let the last request drain
    repeat (8) @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    base_addr = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic alloc_req(input logic [SIZE_W-1:0] bytes);
    answer_t ans;
    send_request(CMD_ALLOC, bytes, $urandom, ans);
    if (ans.st == ST_OK) held_blocks.push_back(ans.addr - base_addr);
  endtask

  task automatic free_req(input logic [ADDR_W-1:0] addr);
    answer_t ans;
    send_request(CMD_FREE, SIZE_W'($urandom), addr, ans);
  endtask

  task automatic test_size_decode();
    alloc_req('0);
    alloc_req(SIZE_W'(TOP_BYTES + 1));
    alloc_req(16'hFFFF);
    alloc_req(16'h8000);
    alloc_req(SIZE_W'(1));
    alloc_req(SIZE_W'(MIN_BLOCK_BYTES));
    alloc_req(SIZE_W'(MIN_BLOCK_BYTES + 1));
    alloc_req(SIZE_W'(128));
    alloc_req(SIZE_W'(256));
    alloc_req(SIZE_W'(512));
    alloc_req(SIZE_W'(1024));
    alloc_req(SIZE_W'(1025));
    alloc_req(SIZE_W'(TOP_BYTES));
  endtask

  task automatic test_free_decode();
    free_req(base_addr);
    // same block again: accepted while the class has room
    free_req(base_addr);
    free_req(base_addr + MIN_BLOCK_BYTES + 37);
    free_req(base_addr + region_offset(NUM_CLASSES) - 1);
    free_req(base_addr + region_offset(NUM_CLASSES));
    free_req(base_addr - 1);
    free_req(base_addr + region_offset(2));
    held_blocks.delete();
  endtask

  task automatic test_class_exhaustion(input int unsigned k);
    int unsigned taken [$];
    int unsigned idx;
    answer_t     ans;
    repeat (BLOCKS_PER_CLASS + 2) begin
      send_request(CMD_ALLOC, size_for_class(k), $urandom, ans);
      if (ans.st == ST_OK) taken.push_back(ans.addr - base_addr);
    end
    while (taken.size() != 0) begin
      idx = $urandom_range(taken.size() - 1, 0);
      send_request(CMD_FREE, SIZE_W'($urandom),
                   base_addr + taken[idx] + $urandom_range(MIN_BLOCK_BYTES - 1, 0), ans);
      taken.delete(idx);
    end
    send_request(CMD_FREE, SIZE_W'($urandom), base_addr + region_offset(k), ans);
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned i;
    int unsigned roll;
    int unsigned alloc_pct;
    int unsigned hot;
    int unsigned idx;
    int unsigned k;
    alloc_pct = 50;
    hot = 0;
    for (i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(2, 0))
          0: alloc_pct = 85;
          1: alloc_pct = 50;
          default: alloc_pct = 15;
        endcase
        hot = $urandom_range(NUM_CLASSES - 1, 0);
        no_idle = ($urandom_range(3, 0) == 0);
      end
      roll = $urandom_range(99, 0);
      if (roll < 10) begin
        case ($urandom_range(3, 0))
          0: alloc_req(SIZE_W'($urandom));
          1: free_req($urandom);
          2: free_req(base_addr + region_offset(NUM_CLASSES) + $urandom_range(4095, 0));
          default: begin
            if (held_blocks.size() != 0)
              free_req(base_addr + held_blocks[$urandom_range(held_blocks.size() - 1, 0)]);
            else
              alloc_req('0);
          end
        endcase
      end else if (roll < 10 + (alloc_pct * 9) / 10 || held_blocks.size() == 0) begin
        // favor one class per stretch so it runs dry
        k = $urandom_range(1, 0) ? hot : $urandom_range(NUM_CLASSES - 1, 0);
        alloc_req(size_for_class(k));
      end else begin
        idx = $urandom_range(held_blocks.size() - 1, 0);
        free_req(base_addr + held_blocks[idx] + $urandom_range(MIN_BLOCK_BYTES - 1, 0));
        held_blocks.delete(idx);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] bases [4];
    int unsigned       c;
    int unsigned       j;
    errors = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_ALLOC;
    req_size = '0;
    free_addr = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    base_addr = '0;
    for (c = 0; c < NUM_CLASSES; c++) begin
      ring_rd[c] = '0;
      ring_wr[c] = '0;
      blocks_free[c] = CNT_W'(BLOCKS_PER_CLASS);
      for (j = 0; j < BLOCKS_PER_CLASS; j++) ring_slot[c][j] = SLOT_W'(j);
    end
    bases[0] = 32'h0000_0000;
    bases[1] = 32'hFFFF_FFFF;
    bases[2] = $urandom & 32'hFFFF_FFC0;
    bases[3] = $urandom;

    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_size_decode();
    test_free_decode();
    // class 0 region wraps past zero at this base
    set_region_base(32'hFFFF_FFC0);
    test_class_exhaustion(2);
    foreach (bases[b]) begin
      set_region_base(bases[b]);
      test_random_traffic(115);
    end

    start = 1'b0;
    wait (answers_due.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
